/* sv/bsfr_pkg.sv */
// bsfr_pkg: shared sizes, register codes and inter-module structs for the
// byte stream find/replace block. No dependencies.
package bsfr_pkg;

  localparam int PATTERN_MAX = 8;
  localparam int REPLACE_MAX = 8;
  localparam int OFFSET_BITS = 32;

  // most results one input byte can cause
  localparam int DESC_BYTES  = 8;
  localparam int IDX_W       = $clog2(DESC_BYTES);
  localparam int LEN_W       = 4;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES      = 8'd0,
    REG_PATTERN_LENGTH     = 8'd1,
    REG_REPLACEMENT_BYTES  = 8'd2,
    REG_REPLACEMENT_LENGTH = 8'd3,
    REG_FIRST_ONLY         = 8'd4
  } cfg_reg_t;

  // live configuration, lengths already clamped
  typedef struct packed {
    logic [63:0]      pattern;
    logic [LEN_W-1:0] plen;
    logic [63:0]      replacement;
    logic [LEN_W-1:0] rlen;
    logic             first_only;
  } cfg_t;

  // one queued job for the back end: emit bytes[0..count-1]
  typedef struct packed {
    logic [DESC_BYTES-1:0][7:0] bytes;
    logic [LEN_W-1:0]           count;
    logic                       byte_valid;
    logic                       match;
    logic [31:0]                offset;
  } desc_t;

endpackage

/* sv/bsfr_if.sv */
// bsfr_if: valid/ready channel interfaces for the find/replace block
// (byte input, result output, config write). Depends on bsfr_pkg.
interface bsfr_in_if;
  import bsfr_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;
  modport source (output valid, data_byte, stream_end, input ready);
  modport sink   (input valid, data_byte, stream_end, output ready);
endinterface

interface bsfr_out_if;
  import bsfr_pkg::*;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        match_found;
  logic [31:0] match_offset;
  logic        last_of_run;
  modport source (output valid, out_byte, byte_valid, match_found, match_offset,
                  last_of_run, input ready);
  modport sink   (input valid, out_byte, byte_valid, match_found, match_offset,
                  last_of_run, output ready);
endinterface

interface bsfr_cfg_if;
  import bsfr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* sv/byte_stream_find_replace.sv */
// byte_stream_find_replace: top level of the streaming byte find/replace block.
// Depends on bsfr_pkg, bsfr_if, bsfr_cfg, bsfr_front, bsfr_fifo, bsfr_back.
//
// Streaming find and replace on a byte stream. One byte is taken per cycle
// on byte_in; the block finds leftmost, non-overlapping occurrences of a
// pattern of 1..8 bytes and swaps each for a replacement of 0..8 bytes.
// The front end holds the unresolved bytes in a window of flops and compares
// the whole window against the pattern in parallel in the cycle a byte is
// taken, so it sustains one input byte per cycle. Each byte that resolves
// something queues one job in a 4-entry queue; the back end unrolls a job
// into result items, one per cycle unless byte_out stalls, through an output
// register. A plain pass-through byte makes one result, so the steady rate is
// one byte in and one byte out per cycle. A replacement of R bytes or a stream
// end that flushes W window bytes makes R or W results, emitted by the back
// end one after another; the queue absorbs those bursts and byte_in.ready
// drops only when it fills. A match with an empty replacement still
// yields one result (byte_valid low) carrying match_found and the offset.
// Configuration writes are taken at any time (cfg.ready is tied high) but are
// meant to happen only while the block is idle; writing pattern_length drops
// the window contents and restarts the stream position at zero. Register
// indexes beyond the five defined are ignored. Reset: rst, synchronous.
module byte_stream_find_replace (
  input  logic       clk,
  input  logic       rst,
  bsfr_in_if.sink    byte_in,
  bsfr_out_if.source byte_out,
  bsfr_cfg_if.sink   cfg
);
  import bsfr_pkg::*;

  cfg_t  cfg_regs;
  logic  restart;
  logic  q_push;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  desc_t q_wdata;
  desc_t q_rdata;

  // register file; restart pulses with a pattern length write
  bsfr_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .cfg_wr  (cfg),
    .cfg     (cfg_regs),
    .restart (restart)
  );

  // window, position counter, match classification
  bsfr_front u_front (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .cfg     (cfg_regs),
    .restart (restart),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_desc  (q_wdata)
  );

  // decouples the two halves so each stalls on its own
  bsfr_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  // one result transfer per cycle from the current job, unless byte_out stalls
  bsfr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_desc   (q_rdata),
    .q_pop    (q_pop),
    .byte_out (byte_out)
  );

endmodule

/* sv/bsfr_cfg.sv */
// bsfr_cfg: configuration register file with length clamping.
// Depends on bsfr_pkg, bsfr_cfg_if.
module bsfr_cfg (
  input  logic            clk,
  input  logic            rst,
  bsfr_cfg_if.sink        cfg_wr,
  output bsfr_pkg::cfg_t  cfg,
  output logic            restart
);
  import bsfr_pkg::*;

  logic [63:0]      pattern;
  logic [LEN_W-1:0] plen_raw;
  logic [63:0]      replacement;
  logic [LEN_W-1:0] rlen_raw;
  logic             first_only;

  assign cfg_wr.ready = 1'b1;
  // pattern length write restarts the stream in the same edge
  assign restart = cfg_wr.valid && (cfg_wr.index == REG_PATTERN_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern     <= '0;
      plen_raw    <= LEN_W'(1);
      replacement <= '0;
      rlen_raw    <= '0;
      first_only  <= 1'b0;
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_PATTERN_BYTES:      pattern     <= cfg_wr.data[63:0];
        REG_PATTERN_LENGTH:     plen_raw    <= cfg_wr.data[LEN_W-1:0];
        REG_REPLACEMENT_BYTES:  replacement <= cfg_wr.data[63:0];
        REG_REPLACEMENT_LENGTH: rlen_raw    <= cfg_wr.data[LEN_W-1:0];
        REG_FIRST_ONLY:         first_only  <= cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.pattern     = pattern;
    cfg.replacement = replacement;
    cfg.first_only  = first_only;
    if (plen_raw == '0)
      cfg.plen = LEN_W'(1);
    else if (plen_raw > LEN_W'(PATTERN_MAX))
      cfg.plen = LEN_W'(PATTERN_MAX);
    else
      cfg.plen = plen_raw;
    cfg.rlen = (rlen_raw > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : rlen_raw;
  end

endmodule

/* sv/bsfr_front.sv */
// bsfr_front: accepts bytes, keeps the match window and stream position,
// classifies each byte and queues a result job. Depends on bsfr_pkg, bsfr_in_if.
module bsfr_front (
  input  logic            clk,
  input  logic            rst,
  bsfr_in_if.sink         byte_in,
  input  bsfr_pkg::cfg_t  cfg,
  input  logic            restart,
  input  logic            q_full,
  output logic            q_push,
  output bsfr_pkg::desc_t q_desc
);
  import bsfr_pkg::*;

  logic [7:0]             win       [PATTERN_MAX];
  logic [7:0]             win_ins   [PATTERN_MAX];
  logic [7:0]             win_shift [PATTERN_MAX];
  logic [LEN_W-1:0]       fill;
  logic [LEN_W-1:0]       fill_ins;
  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS-1:0] start;
  logic                   first_replaced;
  logic                   accept;
  logic                   full;
  logic                   match_all;
  logic                   hit;

  assign byte_in.ready = !q_full;

  always_comb begin
    accept   = byte_in.valid && byte_in.ready;
    fill_ins = fill + LEN_W'(1);
    for (int i = 0; i < PATTERN_MAX; i++)
      win_ins[i] = (LEN_W'(i) == fill) ? byte_in.data_byte : win[i];
    for (int i = 0; i < PATTERN_MAX - 1; i++)
      win_shift[i] = win_ins[i+1];
    win_shift[PATTERN_MAX-1] = win_ins[PATTERN_MAX-1];

    full      = (fill_ins == cfg.plen);
    match_all = 1'b1;
    for (int i = 0; i < PATTERN_MAX; i++)
      if ((LEN_W'(i) < cfg.plen) && (win_ins[i] != cfg.pattern[8*i +: 8]))
        match_all = 1'b0;
    hit   = full && match_all && !(cfg.first_only && first_replaced);
    start = pos - OFFSET_BITS'(cfg.plen) + OFFSET_BITS'(1);

    // job: replacement on a hit, otherwise the oldest byte (or whole window at end)
    for (int i = 0; i < DESC_BYTES; i++) begin
      if (hit)
        q_desc.bytes[i] = cfg.replacement[8*i +: 8];
      else if (i < PATTERN_MAX)
        q_desc.bytes[i] = win_ins[i];
      else
        q_desc.bytes[i] = 8'h00;
    end
    if (hit)
      q_desc.count = (cfg.rlen == '0) ? LEN_W'(1) : cfg.rlen;
    else
      q_desc.count = byte_in.stream_end ? fill_ins : LEN_W'(1);
    q_desc.byte_valid = !(hit && (cfg.rlen == '0));
    q_desc.match      = hit;
    q_desc.offset     = hit ? 32'(start) : 32'd0;
    q_push            = accept && (full || byte_in.stream_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill           <= '0;
      pos            <= '0;
      first_replaced <= 1'b0;
    end else if (restart) begin
      fill           <= '0;
      pos            <= '0;
      first_replaced <= 1'b0;
    end else if (accept) begin
      pos            <= byte_in.stream_end ? '0 : pos + OFFSET_BITS'(1);
      first_replaced <= byte_in.stream_end ? 1'b0 : (first_replaced || hit);
      if (byte_in.stream_end || hit)
        fill <= '0;
      else if (!full)
        fill <= fill_ins;
    end
  end

  // window contents; only entries below fill are ever read
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < PATTERN_MAX; i++)
        win[i] <= full ? win_shift[i] : win_ins[i];
    end
  end

  a_fill_below_plen: assert property (@(posedge clk) disable iff (rst)
    fill < cfg.plen)
    else $error("window fill reached pattern length");

endmodule

/* sv/bsfr_fifo.sv */
// bsfr_fifo: short job queue between front and back end.
// Depends on bsfr_pkg.
module bsfr_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bsfr_pkg::desc_t wdata,
  output logic            full,
  input  logic            pop,
  output bsfr_pkg::desc_t rdata,
  output logic            valid
);
  import bsfr_pkg::*;

  desc_t          mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W+1)'(FIFO_DEPTH));
  assign valid = (count != '0);
  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)
        rd_ptr <= rd_ptr + PTR_W'(1);
      if (push && !pop)
        count <= count + (PTR_W+1)'(1);
      else if (pop && !push)
        count <= count - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr] <= wdata;
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("job queue overrun");

endmodule

/* sv/bsfr_back.sv */
// bsfr_back: expands queued jobs into result items, one per cycle unless the
// output stalls, into an output register. Depends on bsfr_pkg, bsfr_out_if.
module bsfr_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  bsfr_pkg::desc_t q_desc,
  output logic            q_pop,
  bsfr_out_if.source      byte_out
);
  import bsfr_pkg::*;

  desc_t            cur;
  logic             cur_valid;
  logic [IDX_W-1:0] idx;
  logic             ovalid;
  logic [7:0]       o_byte;
  logic             o_bval;
  logic             o_match;
  logic [31:0]      o_offset;
  logic             o_last;
  logic             load_out;
  logic             step;
  logic             last;
  logic             cur_done;

  assign byte_out.valid        = ovalid;
  assign byte_out.out_byte     = o_byte;
  assign byte_out.byte_valid   = o_bval;
  assign byte_out.match_found  = o_match;
  assign byte_out.match_offset = o_offset;
  assign byte_out.last_of_run  = o_last;

  always_comb begin
    load_out = !ovalid || byte_out.ready;
    step     = load_out && cur_valid;
    last     = ((LEN_W'(idx) + LEN_W'(1)) == cur.count);
    cur_done = step && last;
    q_pop    = q_valid && (!cur_valid || cur_done);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      ovalid    <= 1'b0;
    end else begin
      if (load_out)
        ovalid <= cur_valid;
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (cur_done) begin
        cur_valid <= 1'b0;
      end else if (step) begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop)
      cur <= q_desc;
    if (step) begin
      o_byte   <= cur.byte_valid ? cur.bytes[idx] : 8'h00;
      o_bval   <= cur.byte_valid;
      o_match  <= cur.match && (idx == '0);
      o_offset <= (cur.match && (idx == '0)) ? cur.offset : 32'd0;
      o_last   <= last;
    end
  end

  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> (LEN_W'(idx) < cur.count))
    else $error("result index past job length");

  a_done_marks_last: assert property (@(posedge clk) disable iff (rst)
    cur_done |=> (byte_out.valid && byte_out.last_of_run))
    else $error("finished job did not present last result");

endmodule
